[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tcmbc_pkg.sv]
`timescale 1ns / 1ps

package tcmbc_pkg;

  localparam int unsigned ROUND_COUNT_DEFAULT = 32;

  localparam logic [31:0] TEA_DELTA   = 32'h9E3779B9;
  localparam int unsigned TEA_SHIFT_L = 4;
  localparam int unsigned TEA_SHIFT_R = 5;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_WORD_ZERO  = 3'd0,
    REG_KEY_WORD_ONE   = 3'd1,
    REG_KEY_WORD_TWO   = 3'd2,
    REG_KEY_WORD_THREE = 3'd3,
    REG_NONCE_PART_A   = 3'd4,
    REG_NONCE_PART_B   = 3'd5
  } reg_index_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted input beat
    logic start;  // seed the cipher state from nonce plus block index
    logic round;  // run one cipher round
    logic emit;   // load the result register and advance the position
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_zero;  // the next byte opens a new 8-byte block
    logic out_free;   // the result register can take a value this cycle
  } status_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    tea_mix = ((x << TEA_SHIFT_L) + ka) ^ (x + sum) ^ ((x >> TEA_SHIFT_R) + kb);
  endfunction

endpackage

[rtl/core/tcmbc_ctrl.sv]
`timescale 1ns / 1ps

module tcmbc_ctrl
  import tcmbc_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    data_valid,
  output logic    data_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int unsigned CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUND_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] round_cnt;
  logic             accept;

  assign data_stall = (state != ST_IDLE);
  assign accept     = data_valid && (state == ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.load  = accept;
    cmd.start = accept && status.slot_zero;
    cmd.round = (state == ST_ROUND);
    cmd.emit  = (state == ST_EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            round_cnt <= '0;
            state     <= status.slot_zero ? ST_ROUND : ST_EMIT;
          end
        end
        ST_ROUND: begin
          round_cnt <= round_cnt + 1'b1;
          if (round_cnt == CNT_LAST) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/tcmbc_dp.sv]
`timescale 1ns / 1ps

module tcmbc_dp
  import tcmbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]             data_byte,
  input  logic                   last_of_message,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  logic [31:0] key_word_zero;
  logic [31:0] key_word_one;
  logic [31:0] key_word_two;
  logic [31:0] key_word_three;
  logic [63:0] nonce_part_a;
  logic [63:0] nonce_part_b;

  logic [63:0] block_index;
  logic [2:0]  byte_slot;
  logic [31:0] v0;
  logic [31:0] v1;
  logic [31:0] sum;
  logic [7:0]  data_q;
  logic        last_q;

  logic [63:0] counter;
  logic [31:0] sum_next;
  logic [31:0] v0_next;
  logic [31:0] v1_next;
  logic [63:0] ks_block;
  logic [7:0]  ks_byte;

  assign status.slot_zero = (byte_slot == 3'd0);
  assign status.out_free  = !result_valid || !result_stall;

  assign counter  = (nonce_part_a ^ nonce_part_b) + block_index;
  assign sum_next = sum + TEA_DELTA;
  assign v0_next  = v0 + tea_mix(v1, sum, key_word_zero, key_word_one);
  assign v1_next  = v1 + tea_mix(v0_next, sum, key_word_two, key_word_three);

  // The finished cipher state doubles as the keystream for the rest of the block.
  assign ks_block = {v1, v0};
  assign ks_byte  = ks_block[{byte_slot, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_zero  <= '0;
      key_word_one   <= '0;
      key_word_two   <= '0;
      key_word_three <= '0;
      nonce_part_a   <= '0;
      nonce_part_b   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_KEY_WORD_ZERO:  key_word_zero  <= cfg_data[31:0];
        REG_KEY_WORD_ONE:   key_word_one   <= cfg_data[31:0];
        REG_KEY_WORD_TWO:   key_word_two   <= cfg_data[31:0];
        REG_KEY_WORD_THREE: key_word_three <= cfg_data[31:0];
        REG_NONCE_PART_A:   nonce_part_a   <= cfg_data;
        REG_NONCE_PART_B:   nonce_part_b   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= '0;
      v1 <= '0;
    end else if (cmd.start) begin
      v0 <= counter[31:0];
      v1 <= counter[63:32];
    end else if (cmd.round) begin
      v0 <= v0_next;
      v1 <= v1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum <= TEA_DELTA;
    end else if (cmd.round) begin
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_q <= data_byte;
      last_q <= last_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_index <= '0;
      byte_slot   <= '0;
    end else if (cmd.emit) begin
      if (last_q) begin
        block_index <= '0;
        byte_slot   <= '0;
      end else begin
        byte_slot <= byte_slot + 1'b1;
        if (byte_slot == 3'd7) begin
          block_index <= block_index + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= data_q ^ ks_byte;
      out_last <= last_q;
    end
  end

endmodule

[rtl/core/tea_counter_mode_byte_cipher.sv]
`timescale 1ns / 1ps
// Channel  Beat handshake              Payload
// input    data_valid / data_stall     data_byte, last_of_message
// result   result_valid / result_stall out_byte, out_last
// config   cfg_write_en                cfg_index, cfg_data
//
// A beat that opens an 8-byte block is captured, then runs its TEA rounds, one per cycle
// in a single shared round unit, and is then emitted once the result register is free.
// Every other beat is captured and emitted without rounds; one beat is in work at a time.
// Reset (rst, synchronous) clears the registers, block index, byte position and keystream.
// A stalled result holds in the output register; the next beat may be taken meanwhile
// and waits to emit until that register drains.

`include "assert_macros.svh"

module tea_counter_mode_byte_cipher
  import tcmbc_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   data_valid,
  output logic                   data_stall,
  input  logic [7:0]             data_byte,
  input  logic                   last_of_message,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  cmd_t    cmd;
  status_t status;

  tcmbc_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .status     (status),
    .cmd        (cmd)
  );

  tcmbc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .data_byte       (data_byte),
    .last_of_message (last_of_message),
    .cmd             (cmd),
    .status          (status),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

  `ASSERT_IMPL(a_emit_into_free_reg, cmd.emit, !result_valid || !result_stall, "emit into a held result")
  `ASSERT_IMPL(a_no_accept_in_rounds, cmd.round, data_stall, "input open while rounds run")
  `ASSERT_NEXT(a_stall_after_accept, data_valid && !data_stall, data_stall, "second beat taken early")

endmodule

[tb/sv/tea_counter_mode_byte_cipher_tb.sv]
`timescale 1ns / 1ps

module tea_counter_mode_byte_cipher_tb;
  import tcmbc_pkg::*;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_SIX   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_SEVEN = 3'd7;

  localparam int unsigned RANDOM_ROUNDS   = 5;
  localparam int unsigned BEATS_PER_ROUND = 250;
  localparam int unsigned SETTLE_CYCLES   = ROUND_COUNT_DEFAULT + 8;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } cipher_beat_t;

  class cipher_ledger;
    logic [31:0]  key_word [4];
    logic [63:0]  nonce_a;
    logic [63:0]  nonce_b;
    logic [63:0]  block_index;
    logic [63:0]  keystream;
    logic [2:0]   byte_slot;
    cipher_beat_t expected_beats [$];
    int unsigned  failures;

    function new();
      foreach (key_word[i]) key_word[i] = '0;
      nonce_a     = '0;
      nonce_b     = '0;
      block_index = '0;
      keystream   = '0;
      byte_slot   = '0;
      failures    = 0;
    endfunction

    function logic [63:0] tea_keystream(input logic [63:0] counter);
      logic [31:0] v0;
      logic [31:0] v1;
      logic [31:0] acc;
      v0  = counter[31:0];
      v1  = counter[63:32];
      acc = '0;
      for (int r = 0; r < ROUND_COUNT_DEFAULT; r++) begin
        acc = acc + TEA_DELTA;
        v0 = v0 + (((v1 << TEA_SHIFT_L) + key_word[0]) ^ (v1 + acc) ^
                   ((v1 >> TEA_SHIFT_R) + key_word[1]));
        v1 = v1 + (((v0 << TEA_SHIFT_L) + key_word[2]) ^ (v0 + acc) ^
                   ((v0 >> TEA_SHIFT_R) + key_word[3]));
      end
      return {v1, v0};
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] index,
                          input logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_KEY_WORD_ZERO:  key_word[0] = value[31:0];
        REG_KEY_WORD_ONE:   key_word[1] = value[31:0];
        REG_KEY_WORD_TWO:   key_word[2] = value[31:0];
        REG_KEY_WORD_THREE: key_word[3] = value[31:0];
        REG_NONCE_PART_A:   nonce_a = value;
        REG_NONCE_PART_B:   nonce_b = value;
        default: ;
      endcase
    endfunction

    // The keystream is fixed when a block opens, so later register writes
    // only show up at the next block.
    function void note_input(input logic [7:0] data, input logic closing);
      cipher_beat_t beat;
      if (byte_slot == 3'd0) keystream = tea_keystream((nonce_a ^ nonce_b) + block_index);
      beat.out_byte = data ^ keystream[8*byte_slot +: 8];
      beat.out_last = closing;
      expected_beats.push_back(beat);
      if (closing) begin
        byte_slot   = '0;
        block_index = '0;
      end else begin
        byte_slot = byte_slot + 3'd1;
        if (byte_slot == 3'd0) block_index = block_index + 64'd1;
      end
    endfunction

    function void check_result(input logic [7:0] got_byte, input logic got_last);
      cipher_beat_t want;
      if (expected_beats.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result beat with nothing outstanding: out_byte %02h out_last %0b",
                   got_byte, got_last);
        return;
      end
      want = expected_beats.pop_front();
      if (got_byte !== want.out_byte || got_last !== want.out_last) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result beat: out_byte expected %02h got %02h, out_last expected %0b got %0b",
                   want.out_byte, got_byte, want.out_last, got_last);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   data_valid = 1'b0;
  logic                   data_stall;
  logic [7:0]             data_byte = '0;
  logic                   last_of_message = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [7:0]             out_byte;
  logic                   out_last;

  cipher_ledger ledger;

  bit          calm = 1'b0;
  int unsigned calm_left = 0;

  tea_counter_mode_byte_cipher i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .data_valid      (data_valid),
    .data_stall      (data_stall),
    .data_byte       (data_byte),
    .last_of_message (last_of_message),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

  always #2 clk = ~clk;

  // Now and then both sides run without any idle cycles for a while.
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(20, 80);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] value, input logic closing);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid      <= 1'b1;
    data_byte       <= value;
    last_of_message <= closing;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    ledger.note_input(value, closing);
  endtask

  task automatic wait_for_quiet();
    data_valid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_beats.size() != 0) @(posedge clk);
  endtask

  // The caller drops the write enable after its last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= index;
    cfg_data     <= value;
    @(posedge clk);
    ledger.set_reg(index, value);
  endtask

  task automatic retune();
    write_reg(REG_KEY_WORD_ZERO, pick_value());
    write_reg(REG_KEY_WORD_ONE, pick_value());
    write_reg(REG_KEY_WORD_TWO, pick_value());
    write_reg(REG_KEY_WORD_THREE, pick_value());
    write_reg(REG_NONCE_PART_A, pick_value());
    write_reg(REG_NONCE_PART_B, pick_value());
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? REG_SPARE_SIX : REG_SPARE_SEVEN, pick_value());
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    int unsigned hold;
    wait (!rst);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      ledger.check_result(out_byte, out_last);
    end
  end

  initial begin
    int unsigned    msg_left;
    logic [63:0]    shared_nonce;
    ledger = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // All registers still at their reset values.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hA5, 1'b1);
    wait_for_quiet();

    // An all-ones nonce makes the counter wrap to zero on the second block.
    write_reg(REG_KEY_WORD_ZERO, '1);
    write_reg(REG_KEY_WORD_ONE, '1);
    write_reg(REG_KEY_WORD_TWO, '1);
    write_reg(REG_KEY_WORD_THREE, '1);
    write_reg(REG_NONCE_PART_A, '1);
    write_reg(REG_NONCE_PART_B, '0);
    write_reg(REG_SPARE_SIX, {$urandom, $urandom});
    write_reg(REG_SPARE_SEVEN, '1);
    cfg_write_en <= 1'b0;
    for (int i = 0; i < 9; i++) send_beat(i[0] ? 8'hFF : 8'h00, i == 8);
    wait_for_quiet();

    // Equal nonce halves cancel; then a key change lands in the middle of a block.
    shared_nonce = {$urandom, $urandom};
    write_reg(REG_KEY_WORD_ZERO, '0);
    write_reg(REG_KEY_WORD_ONE, '0);
    write_reg(REG_KEY_WORD_TWO, '0);
    write_reg(REG_KEY_WORD_THREE, '0);
    write_reg(REG_NONCE_PART_A, shared_nonce);
    write_reg(REG_NONCE_PART_B, shared_nonce);
    cfg_write_en <= 1'b0;
    for (int i = 0; i < 3; i++) send_beat(8'($urandom_range(0, 255)), 1'b0);
    wait_for_quiet();
    write_reg(REG_KEY_WORD_TWO, {$urandom, $urandom});
    cfg_write_en <= 1'b0;
    for (int i = 0; i < 6; i++) send_beat(8'($urandom_range(0, 255)), i == 5);

    // Random messages of mixed length; a message may straddle a register change.
    msg_left = 0;
    for (int round_no = 0; round_no < RANDOM_ROUNDS; round_no++) begin
      wait_for_quiet();
      retune();
      for (int n = 0; n < BEATS_PER_ROUND; n++) begin
        if (msg_left == 0)
          msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
                                                 : $urandom_range(1, 24);
        send_beat(8'($urandom_range(0, 255)), msg_left == 1);
        msg_left--;
      end
    end

    wait_for_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.failures == 0) begin
      $display("tea_counter_mode_byte_cipher: match");
    end else begin
      $display("tea_counter_mode_byte_cipher: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tea_counter_mode_byte_cipher: mismatch");
    $finish;
  end

endmodule
